FILE: rtl/core/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types and constants for the multi-axis step pulse generator: word
// layouts of the tick and result channels, field widths, reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package msp_pkg;

    // Defaults for the top-level parameters
    localparam int CHANNELS_DEF      = 8;
    localparam int POSITION_BITS_DEF = 17;
    localparam int DIVIDER_BITS_DEF  = 6;

    // Fixed field widths of the channel words
    localparam int ENDSTOPS_W = 8;
    localparam int CHANNEL_W  = 3;
    localparam int TARGET_W   = 17;
    localparam int DIVIDER_W  = 6;
    localparam int MASK_W     = 8;
    localparam int POSITION_W = 17;

    // Position of every channel after reset
    localparam int POS_RESET = 10;

    // Level of an endstop input that reads as switch hit
    localparam logic ENDSTOP_HIT = 1'b1;

    // One tick word
    typedef struct packed {
        logic [ENDSTOPS_W-1:0] endstops;
        logic                  load_target;
        logic [CHANNEL_W-1:0]  channel;
        logic [TARGET_W-1:0]   new_target;
        logic [DIVIDER_W-1:0]  divider;
    } in_word_t;

    // One result word
    typedef struct packed {
        logic [MASK_W-1:0]     step_pulses;
        logic [MASK_W-1:0]     directions;
        logic [MASK_W-1:0]     at_target;
        logic [POSITION_W-1:0] position;
    } out_word_t;

    // Per-channel outcome of one update
    typedef struct packed {
        logic pulse;
        logic dir;
        logic at;
    } step_flags_t;

endpackage

`default_nettype wire

FILE: rtl/core/msp_if.sv
// ----------------------------------------------------------------------------
// msp_if
// Valid/ready channels of the step pulse generator: tick words in, result
// words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface msp_in_if;
    import msp_pkg::*;

    logic     valid;
    logic     ready;
    in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface msp_out_if;
    import msp_pkg::*;

    logic      valid;
    logic      ready;
    out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/msp_mod_unit.sv
// ----------------------------------------------------------------------------
// msp_mod_unit
// Restoring remainder unit: one dividend bit per cycle over all DIVIDER_BITS+1
// dividend bits, then a one-cycle done pulse with the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_mod_unit #(
    parameter int DIVIDER_BITS = msp_pkg::DIVIDER_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [DIVIDER_BITS:0]   dividend,
    input  logic [DIVIDER_BITS-1:0] divisor,
    output logic                    done,
    output logic [DIVIDER_BITS-1:0] rem
);
    import msp_pkg::*;

    localparam int STEP_W = $clog2(DIVIDER_BITS + 1);

    logic                    busy_reg;
    logic                    done_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [DIVIDER_BITS:0]   x_reg;
    logic [DIVIDER_BITS-1:0] r_reg;

    logic [DIVIDER_BITS:0]   trial;
    logic [DIVIDER_BITS:0]   div_ext;
    logic [DIVIDER_BITS:0]   r_next;

    // Shift in the next dividend bit, subtract the divisor where it fits
    assign trial   = {r_reg, x_reg[DIVIDER_BITS]};
    assign div_ext = {1'b0, divisor};
    assign r_next  = (trial >= div_ext) ? (trial - div_ext) : trial;

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DIVIDER_BITS);
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    // Partial remainder and dividend shifter
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= dividend;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg <= x_reg << 1;
            r_reg <= r_next[DIVIDER_BITS-1:0];
        end
    end

    assign done = done_reg;
    assign rem  = r_reg;

endmodule

`default_nettype wire

FILE: rtl/core/msp_step_unit.sv
// ----------------------------------------------------------------------------
// msp_step_unit
// Update of one channel for one tick: step toward the target or home
// against the endstop, with pulse, direction and at-target flags.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_step_unit #(
    parameter int POSITION_BITS = msp_pkg::POSITION_BITS_DEF
) (
    input  logic [POSITION_BITS-1:0] pos,
    input  logic [POSITION_BITS-1:0] tgt,
    input  logic                     wrap,
    input  logic                     hit,
    output logic [POSITION_BITS-1:0] next_pos,
    output msp_pkg::step_flags_t     flags
);
    import msp_pkg::*;

    logic below;
    logic homing;

    assign below  = pos < tgt;
    assign homing = (tgt == '0);

    // Move one step, zero on endstop, or pulse down while homing
    always_comb
    begin
        next_pos    = pos;
        flags.pulse = 1'b0;
        flags.dir   = below;
        priority if (!homing)
        begin
            if (wrap && (pos != tgt))
            begin
                flags.pulse = 1'b1;
                next_pos    = below ? (pos + 1'b1) : (pos - 1'b1);
            end
        end
        else if (hit)
        begin
            next_pos = '0;
        end
        else
        begin
            // hold the position and pulse down until the endstop reads hit
            if (wrap && (pos != '0))
            begin
                flags.pulse = 1'b1;
            end
        end
        flags.at = (next_pos == tgt);
    end

endmodule

`default_nettype wire

FILE: rtl/core/multi_axis_step_pulse_generator_unit.sv
// ----------------------------------------------------------------------------
// multi_axis_step_pulse_generator_unit
// Step/direction generator for several stepper channels, one tick per word.
// ----------------------------------------------------------------------------
// Each accepted tick word optionally loads a new target into the addressed
// channel, then a sequencer walks the channels one per cycle through a single
// shared update unit (rate count, step toward target or homing), save while a
// channel waits on the remainder unit. A new tick is taken only once the sweep
// has ended; the result word is then held in an output register, so the next
// tick is taken while it waits. A channel whose count plus one exceeds the
// divider (the divider was lowered below it) goes through the bit-serial
// remainder unit, which lengthens the sweep of that tick. A target of zero
// homes the channel against its endstop.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_axis_step_pulse_generator_unit #(
    parameter int CHANNELS      = msp_pkg::CHANNELS_DEF,
    parameter int POSITION_BITS = msp_pkg::POSITION_BITS_DEF,
    parameter int DIVIDER_BITS  = msp_pkg::DIVIDER_BITS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    msp_in_if.sink   tick,
    msp_out_if.source result
);
    import msp_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_MOD  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // Control state
    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [IDX_W-1:0] idx_reg;
    logic             out_valid_reg;

    // Per-channel state
    logic [POSITION_BITS-1:0] pos_arr_reg [CHANNELS];
    logic [POSITION_BITS-1:0] tgt_arr_reg [CHANNELS];
    logic [DIVIDER_BITS-1:0]  cnt_arr_reg [CHANNELS];

    // Tick word held for the sweep
    logic [ENDSTOPS_W-1:0]    ends_reg;
    logic [DIVIDER_BITS-1:0]  div_reg;
    logic [CHANNEL_W-1:0]     ch_reg;

    // Result collection
    logic [CHANNELS-1:0]      pulse_acc_reg;
    logic [CHANNELS-1:0]      dir_acc_reg;
    logic [CHANNELS-1:0]      at_acc_reg;
    logic [POSITION_W-1:0]    pos_cap_reg;
    out_word_t                out_word_reg;

    logic                     in_fire;
    logic                     out_fire;
    logic                     in_ch_ok;
    logic                     ch_ok;
    logic [DIVIDER_BITS-1:0]  div_in;
    logic [DIVIDER_BITS-1:0]  div_eff;
    logic [POSITION_BITS-1:0] cur_pos;
    logic [POSITION_BITS-1:0] cur_tgt;
    logic [DIVIDER_BITS-1:0]  cur_cnt;
    logic [DIVIDER_BITS:0]    cnt_inc;
    logic [DIVIDER_BITS:0]    div_ext;
    logic                     fast;
    logic [DIVIDER_BITS-1:0]  cnt_fast;
    logic [DIVIDER_BITS-1:0]  cnt_new;
    logic                     apply;
    logic                     mod_start;
    logic                     mod_done;
    logic [DIVIDER_BITS-1:0]  mod_rem;
    logic [ENDSTOPS_W-1:0]    ends_shift;
    logic                     hit;
    logic                     readback;
    logic [POSITION_BITS-1:0] step_pos;
    step_flags_t              step_flags;
    logic                     last;

    // Handshakes
    assign tick.ready   = (state_reg == S_IDLE);
    assign in_fire      = tick.valid && tick.ready;
    assign out_fire     = out_valid_reg && result.ready;
    assign result.valid = out_valid_reg;
    assign result.data  = out_word_reg;

    // Tick word decode
    assign in_ch_ok = int'(tick.data.channel) < CHANNELS;
    assign ch_ok    = int'(ch_reg) < CHANNELS;
    assign div_in   = DIVIDER_BITS'(tick.data.divider);
    assign div_eff  = (div_in == '0) ? DIVIDER_BITS'(1) : div_in;

    // Channel under update
    assign cur_pos = pos_arr_reg[idx_reg];
    assign cur_tgt = tgt_arr_reg[idx_reg];
    assign cur_cnt = cnt_arr_reg[idx_reg];

    // Advance the rate count; fall back to the remainder unit when it overshoots
    assign cnt_inc  = {1'b0, cur_cnt} + 1'b1;
    assign div_ext  = {1'b0, div_reg};
    assign fast     = (cnt_inc <= div_ext);
    assign cnt_fast = (cnt_inc == div_ext) ? '0 : cnt_inc[DIVIDER_BITS-1:0];
    assign cnt_new  = (state_reg == S_CALC) ? cnt_fast : mod_rem;

    assign mod_start = (state_reg == S_CALC) && !fast;
    assign apply     = ((state_reg == S_CALC) && fast) || ((state_reg == S_MOD) && mod_done);
    assign last      = (idx_reg == LAST_IDX);

    // Endstop of the current channel; channels past the input read as open
    assign ends_shift = ends_reg >> idx_reg;
    assign hit        = (ends_shift[0] == ENDSTOP_HIT);
    assign readback   = ch_ok && (IDX_W'(ch_reg) == idx_reg);

    msp_mod_unit #(
        .DIVIDER_BITS (DIVIDER_BITS)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (cnt_inc),
        .divisor  (div_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    msp_step_unit #(
        .POSITION_BITS (POSITION_BITS)
    ) u_step (
        .pos      (cur_pos),
        .tgt      (cur_tgt),
        .wrap     (cnt_new == '0),
        .hit      (hit),
        .next_pos (step_pos),
        .flags    (step_flags)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                if (!fast)
                begin
                    state_next = S_MOD;
                end
                else if (last)
                begin
                    state_next = S_DONE;
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    state_next = last ? S_DONE : S_CALC;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers and channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                pos_arr_reg[i] <= POSITION_BITS'(POS_RESET);
                tgt_arr_reg[i] <= '0;
                cnt_arr_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            // Load the target before the sweep
            if (in_fire)
            begin
                idx_reg <= '0;
                if (tick.data.load_target && in_ch_ok)
                begin
                    tgt_arr_reg[IDX_W'(tick.data.channel)] <=
                        POSITION_BITS'(tick.data.new_target);
                end
            end

            // Write back the updated channel and advance
            if (apply)
            begin
                pos_arr_reg[idx_reg] <= step_pos;
                cnt_arr_reg[idx_reg] <= cnt_new;
                if (!last)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end

            // Hand the result word to the output register
            if ((state_reg == S_DONE) && (!out_valid_reg || result.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Tick word capture and result collection
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ends_reg    <= tick.data.endstops;
            div_reg     <= div_eff;
            ch_reg      <= tick.data.channel;
            pos_cap_reg <= '0;
        end
        if (apply)
        begin
            pulse_acc_reg[idx_reg] <= step_flags.pulse;
            dir_acc_reg[idx_reg]   <= step_flags.dir;
            at_acc_reg[idx_reg]    <= step_flags.at;
            if (readback)
            begin
                pos_cap_reg <= POSITION_W'(step_pos);
            end
        end
        if ((state_reg == S_DONE) && (!out_valid_reg || result.ready))
        begin
            out_word_reg.step_pulses <= MASK_W'(pulse_acc_reg);
            out_word_reg.directions  <= MASK_W'(dir_acc_reg);
            out_word_reg.at_target   <= MASK_W'(at_acc_reg);
            out_word_reg.position    <= pos_cap_reg;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/msp_checker.sv
// ----------------------------------------------------------------------------
// msp_checker
// Port-level checks of the step pulse generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_checker (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    input  wire                 in_ready,
    input  wire                 out_valid,
    input  wire                 out_ready,
    input  msp_pkg::out_word_t  out_data
);
    import msp_pkg::*;

    // The sequencer is busy right after it takes a tick word
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("tick ready stayed high after an accepted word");

    // A result never shows up on the cycle right after a tick is taken
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
        else $error("result appeared right after tick acceptance");

    // A stalled result stays offered
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result valid dropped under stall");

    // A stalled result keeps its word
    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(out_data))
        else $error("result word changed under stall");

endmodule

bind multi_axis_step_pulse_generator_unit msp_checker u_msp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (tick.valid),
    .in_ready  (tick.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multi-axis step pulse generator unit.
// ----------------------------------------------------------------------------
// Tick words go in on a valid/ready channel. An in-bench model of the eight
// axes (positions, targets, rate counts) predicts each result word. Every
// result word is compared field by field with the oldest prediction. A short
// table of directed ticks comes first: reset homing, endstop zeroing, extreme
// targets and dividers, and a divider lowered below the running count. Random
// target moves, homing runs and divider changes follow. Both sides idle at
// random, and the result side is held off for a long stretch once.
// ----------------------------------------------------------------------------

module tb;
    import msp_pkg::*;

    localparam int RANDOM_TICKS = 1400;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int LONG_HOLD    = 400;
    localparam int TAIL_CYCLES  = 120;
    localparam int AXES         = CHANNELS_DEF;

    // Stall patterns of the result side
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE} rx_mode_e;

    typedef struct {
        in_word_t  word;
        bit        typed;
        out_word_t want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;

    msp_in_if  tick_if ();
    msp_out_if result_if ();

    multi_axis_step_pulse_generator_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_if),
        .result (result_if)
    );

    // Axis model state
    logic [POSITION_W-1:0] axis_pos   [AXES];
    logic [TARGET_W-1:0]   axis_goal  [AXES];
    logic [DIVIDER_W-1:0]  axis_count [AXES];
    logic [DIVIDER_W-1:0]  cur_div;

    out_word_t expected_q [$];
    plan_row_t plan_rows [$];

    int  errors        = 0;
    int  cycle_count   = 0;
    int  ticks_sent    = 0;
    int  results_seen  = 0;
    int  pulses_seen   = 0;
    int  homed_seen    = 0;
    bit  long_stall_go = 1'b0;
    bit  long_stall_done = 1'b0;

    // Clock: 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Guard against a hang
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still due",
                     cycle_count, expected_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Advance every axis by one tick and return the result word
    function automatic out_word_t advance_axes(in_word_t w);
        out_word_t             o;
        int                    i;
        int                    d;
        int                    cnt;
        bit                    wrap;
        logic [POSITION_W-1:0] p;
        logic [TARGET_W-1:0]   g;
        o = '0;
        d = (w.divider == 0) ? 1 : int'(w.divider);
        if (w.load_target)
            axis_goal[w.channel] = w.new_target;
        for (i = 0; i < AXES; i++)
        begin
            cnt = (int'(axis_count[i]) + 1) % d;
            axis_count[i] = cnt[DIVIDER_W-1:0];
            wrap = (cnt == 0);
            p = axis_pos[i];
            g = axis_goal[i];
            if (p < g)
                o.directions[i] = 1'b1;
            if (g != 0)
            begin
                // step one toward the target on a count wrap
                if (wrap && p != g)
                begin
                    o.step_pulses[i] = 1'b1;
                    p = (p < g) ? p + 1'b1 : p - 1'b1;
                end
            end
            else if (w.endstops[i] == ENDSTOP_HIT)
                p = '0;
            else if (wrap && p != 0)
                o.step_pulses[i] = 1'b1;
            axis_pos[i] = p;
            if (p == g)
                o.at_target[i] = 1'b1;
        end
        o.position = axis_pos[w.channel];
        return o;
    endfunction

    // Build one random tick: mostly target moves and homing, some noise
    function automatic in_word_t next_random_tick();
        in_word_t w;
        int       r;
        int       base;
        w = '0;
        if ($urandom_range(0, 19) == 0)
        begin
            r = $urandom_range(0, 9);
            if (r < 6)
                cur_div = DIVIDER_W'($urandom_range(0, 3));
            else if (r < 9)
                cur_div = DIVIDER_W'($urandom_range(4, 63));
            else
                cur_div = 6'd63;
        end
        w.divider = cur_div;

        r = $urandom_range(0, 9);
        if (r < 6)
            w.endstops = '0;
        else if (r < 8)
            w.endstops = 8'h01 << $urandom_range(0, 7);
        else if (r < 9)
            w.endstops = ENDSTOPS_W'($urandom_range(0, 255));
        else
            w.endstops = 8'hFF;

        w.channel = CHANNEL_W'($urandom_range(0, 7));
        w.load_target = ($urandom_range(0, 9) < 3);

        r = $urandom_range(0, 9);
        if (r < 2)
            w.new_target = '0;
        else if (r < 7)
            w.new_target = TARGET_W'($urandom_range(1, 40));
        else if (r < 8)
        begin
            base = int'(axis_pos[w.channel]) + $urandom_range(0, 10) - 5;
            w.new_target = (base < 0) ? '0 : TARGET_W'(base);
        end
        else if (r < 9)
            w.new_target = TARGET_W'($urandom_range(0, 131071));
        else
            w.new_target = 17'h1FFFF;
        return w;
    endfunction

    task automatic add_row(input logic [7:0] ends, input bit load, input logic [2:0] ch,
                           input logic [16:0] tgt, input logic [5:0] dv, input bit typed,
                           input logic [7:0] pl, input logic [7:0] dr,
                           input logic [7:0] at, input logic [16:0] ps);
        plan_row_t row;
        row.word  = '{endstops: ends, load_target: load, channel: ch,
                      new_target: tgt, divider: dv};
        row.typed = typed;
        row.want  = '{step_pulses: pl, directions: dr, at_target: at, position: ps};
        plan_rows.push_back(row);
    endtask

    // Offer one word and hold it until taken, then log its prediction
    task automatic deliver_tick(input in_word_t w, input bit typed, input out_word_t want);
        out_word_t predicted;
        tick_if.valid <= 1'b1;
        tick_if.data  <= w;
        do
            @(posedge clk);
        while (tick_if.ready !== 1'b1);
        predicted = advance_axes(w);
        expected_q.push_back(typed ? want : predicted);
        ticks_sent++;
    endtask

    // Drop valid and wait until every due word has come back
    task automatic wait_for_drain();
        if (expected_q.size() != 0)
        begin
            tick_if.valid <= 1'b0;
            while (expected_q.size() != 0)
                @(posedge clk);
        end
    endtask

    task automatic idle_gap(input int gap);
        if (gap > 0)
        begin
            tick_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Check each accepted result word against the oldest prediction
    always @(posedge clk)
    begin
        out_word_t want;
        out_word_t got;
        if (rst_n && result_if.valid === 1'b1 && result_if.ready === 1'b1)
        begin
            got = result_if.data;
            results_seen++;
            pulses_seen += $countones(got.step_pulses);
            if (expected_q.size() == 0)
            begin
                $error("result word with nothing due: %h", got);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.step_pulses !== want.step_pulses)
                begin
                    $error("step_pulses: expected %h actual %h",
                           want.step_pulses, got.step_pulses);
                    errors++;
                end
                if (got.directions !== want.directions)
                begin
                    $error("directions: expected %h actual %h",
                           want.directions, got.directions);
                    errors++;
                end
                if (got.at_target !== want.at_target)
                begin
                    $error("at_target: expected %h actual %h",
                           want.at_target, got.at_target);
                    errors++;
                end
                if (got.position !== want.position)
                begin
                    $error("position: expected %0d actual %0d",
                           want.position, got.position);
                    errors++;
                end
                if (want.position == 0 && got.position == 0)
                    homed_seen++;
            end
        end
    end

    // Result side: stall on rotating patterns, plus one long hold-off
    initial
    begin
        rx_mode_e mode;
        int       seg_left;
        int       phase;
        mode = RX_OPEN;
        seg_left = 0;
        phase = 0;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_stall_go && !long_stall_done)
            begin
                // hold off so the unit fills up and stalls its input
                result_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_stall_done = 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode = rx_mode_e'($urandom_range(0, 3));
                    seg_left = $urandom_range(16, 160);
                end
                seg_left--;
                phase++;
                case (mode)
                    RX_OPEN:    result_if.ready <= 1'b1;
                    RX_COIN:    result_if.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:  result_if.ready <= ($urandom_range(0, 3) == 0);
                    RX_CADENCE: result_if.ready <= (phase % 3 == 0);
                    default:    result_if.ready <= 1'b1;
                endcase
            end
        end
    end

    // Stimulus
    initial
    begin
        int i;
        int burst;
        int gap;
        int k;
        int random_sent;
        int directed_count;

        tick_if.valid <= 1'b0;
        tick_if.data  <= '0;
        rst_n = 1'b0;
        cur_div = '0;
        for (i = 0; i < AXES; i++)
        begin
            axis_pos[i]   = POSITION_W'(POS_RESET);
            axis_goal[i]  = '0;
            axis_count[i] = '0;
        end

        // Directed ticks: endstops, load, channel, target, divider, expected word
        // reset state homes every axis, divider zero acts as one
        add_row(8'h00, 0, 3'd0, 17'd0,      6'd0,  1, 8'hFF, 8'h00, 8'h00, 17'd10);
        // all endstops hit: every axis zeroed without a pulse
        add_row(8'hFF, 0, 3'd7, 17'd0,      6'd1,  1, 8'h00, 8'h00, 8'hFF, 17'd0);
        // largest target on axis 0, the rest sit homed at zero
        add_row(8'h00, 1, 3'd0, 17'h1FFFF,  6'd0,  1, 8'h01, 8'h01, 8'hFE, 17'd1);
        // largest divider: counts start, nobody steps
        add_row(8'h00, 1, 3'd1, 17'd1,      6'd63, 1, 8'h00, 8'h03, 8'hFC, 17'd0);
        add_row(8'h00, 0, 3'd1, 17'h15555,  6'd63, 0, '0, '0, '0, '0);
        add_row(8'h00, 0, 3'd1, 17'h0AAAA,  6'd63, 0, '0, '0, '0, '0);
        add_row(8'h00, 0, 3'd0, 17'd0,      6'd63, 0, '0, '0, '0, '0);
        add_row(8'h00, 0, 3'd0, 17'd0,      6'd63, 0, '0, '0, '0, '0);
        // divider lowered below the running count
        add_row(8'h00, 0, 3'd1, 17'd0,      6'd3,  0, '0, '0, '0, '0);
        add_row(8'h00, 1, 3'd2, 17'd5,      6'd1,  0, '0, '0, '0, '0);
        // axis 0 switched to homing while away from zero
        add_row(8'h00, 1, 3'd0, 17'd0,      6'd0,  0, '0, '0, '0, '0);
        add_row(8'h00, 0, 3'd0, 17'd0,      6'd0,  0, '0, '0, '0, '0);
        add_row(8'h01, 0, 3'd0, 17'd0,      6'd0,  0, '0, '0, '0, '0);
        add_row(8'h00, 1, 3'd4, 17'd20,     6'd0,  0, '0, '0, '0, '0);
        add_row(8'h00, 0, 3'd4, 17'd0,      6'd0,  0, '0, '0, '0, '0);
        add_row(8'h00, 0, 3'd4, 17'd0,      6'd2,  0, '0, '0, '0, '0);
        add_row(8'h00, 0, 3'd4, 17'd0,      6'd0,  0, '0, '0, '0, '0);
        // target 3 on axis 4, which it has already reached
        add_row(8'h00, 1, 3'd4, 17'd3,      6'd0,  0, '0, '0, '0, '0);
        add_row(8'hAA, 0, 3'd4, 17'd0,      6'd0,  0, '0, '0, '0, '0);
        add_row(8'h55, 0, 3'd2, 17'd0,      6'd1,  0, '0, '0, '0, '0);
        add_row(8'h00, 1, 3'd7, 17'h1FFFF,  6'd63, 0, '0, '0, '0, '0);
        add_row(8'h55, 0, 3'd5, 17'h1FFFF,  6'd2,  0, '0, '0, '0, '0);
        add_row(8'h00, 1, 3'd6, 17'd12,     6'd0,  0, '0, '0, '0, '0);
        add_row(8'hFF, 0, 3'd6, 17'd0,      6'd0,  0, '0, '0, '0, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (plan_rows[i])
        begin
            deliver_tick(plan_rows[i].word, plan_rows[i].typed, plan_rows[i].want);
            idle_gap($urandom_range(0, 3));
        end
        directed_count = ticks_sent;
        wait_for_drain();

        // Random ticks in bursts
        random_sent = 0;
        while (random_sent < RANDOM_TICKS)
        begin
            burst = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            for (k = 0; k < burst && random_sent < RANDOM_TICKS; k++)
            begin
                if (random_sent == 250)
                    long_stall_go <= 1'b1;
                if (random_sent == 700)
                    wait_for_drain();
                deliver_tick(next_random_tick(), 1'b0, '0);
                random_sent++;
            end
            idle_gap(gap);
        end

        // Drain and let the pipeline settle
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_q.size() != 0)
        begin
            $error("%0d result words never arrived", expected_q.size());
            errors++;
        end

        $display("Sent %0d ticks (%0d from the directed table), checked %0d result words",
                 ticks_sent, directed_count, results_seen);
        $display("Saw %0d step pulses, %0d zero readbacks, %0d mismatches, %0d cycles",
                 pulses_seen, homed_seen, errors, cycle_count);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
